// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/prs_pkg.sv
// Shared types, constants and phase coefficient table of the 3/5 line resampler.
`default_nettype none
package prs_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int NCELL     = 15;
    localparam int HALF_TAPS = 7;
    localparam int POS_W     = 12;
    localparam int WIDTH_W   = 13;
    localparam int MAX_OUT   = 10;
    localparam int CNT_W     = 4;

    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 13'd5;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 13'd4096;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

    // Register index (paddr bit 2)
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_CLIP       = 1'b1;

    // Per-cell control word
    typedef struct packed {
        logic fill;   // load every cell with the incoming word
        logic shift;  // move samples one cell along
        logic mac;    // register sample times coefficient
    } cell_ctl_t;

    // Normalized Q16 taps, phase x tap (tap 0 is the oldest position)
    localparam logic signed [COEF_W-1:0] TAPS [3][NCELL] = '{
        '{ 17'sd19,    -17'sd316,  17'sd0,     17'sd2220,  -17'sd2675,
           -17'sd5115, 17'sd18978, 17'sd39313, 17'sd18978, -17'sd5115,
           -17'sd2675, 17'sd2220,  17'sd0,     -17'sd316,  17'sd19 },
        '{ 17'sd0,     -17'sd491,  17'sd821,   17'sd1730,  -17'sd5349,
           17'sd0,     17'sd29176, 17'sd36597, 17'sd8496,  -17'sd6627,
           17'sd0,     17'sd1735,  -17'sd442,  -17'sd113,  17'sd3 },
        '{ 17'sd3,     -17'sd113,  -17'sd442,  17'sd1735,  17'sd0,
           -17'sd6627, 17'sd8496,  17'sd36597, 17'sd29176, 17'sd0,
           -17'sd5349, 17'sd1730,  17'sd821,   -17'sd491,  17'sd0 }
    };

endpackage
`default_nettype wire

// File: hw/rtl/prs_cell.sv
// One window cell: holds a sample, passes it on, forms its tap product.
`default_nettype none
module prs_cell (
    input  wire logic                                 aclk,
    input  wire prs_pkg::cell_ctl_t                   ctl,
    input  wire logic signed [prs_pkg::SAMPLE_W-1:0]  prev_sample,
    input  wire logic signed [prs_pkg::SAMPLE_W-1:0]  fill_sample,
    input  wire logic signed [prs_pkg::COEF_W-1:0]    coef,
    output logic signed [prs_pkg::SAMPLE_W-1:0]       sample,
    output logic signed [prs_pkg::PROD_W-1:0]         prod
);

    logic signed [prs_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [prs_pkg::PROD_W-1:0]   prod_reg;

    // Sample hold and tap multiply
    always_ff @(posedge aclk) begin
        if (ctl.fill) begin
            sample_reg <= fill_sample;
        end else if (ctl.shift) begin
            sample_reg <= prev_sample;
        end
        if (ctl.mac) begin
            prod_reg <= sample_reg * coef;
        end
    end

    assign sample = sample_reg;
    assign prod   = prod_reg;

endmodule
`default_nettype wire

// File: hw/rtl/polyphase_resample_3_5_line.sv
// Top level of the 3/5 polyphase line resampler.
// Usage: samples of one line enter on the s_ channel, one word each; filtered
// words leave on the m_ channel, m_tlast marking the final output of a line.
// Outputs per line: floor(3*w/5), w being line_width clamped to 5..4096. The
// user is to set line width and clip mode over the APB port while the block
// is idle; the block itself does not enforce this. Samples shift through a
// row of 15 cells; each output is one parallel dot product (cell multiplies,
// 4-way partial sum, final sum and rounding). Words are taken one at a time
// with one result in flight through the product/sum stages; a new word is
// taken only once the results of the last have left, after any m_tready
// stall. The last word of a line flushes up to 4 more outputs by replicating
// the right edge sample. A result passes the cell product, partial sum and
// output registers before m_tvalid rises.
// s_tready is high only between words. A stalled receiver holds m_tdata and
// freezes the block until the word is taken.
// Reset: line width 640, no clip, line position zero; the window cells are
// not cleared (the first word of each line fills them).
`default_nettype none
`include "assert_macros.svh"
module polyphase_resample_3_5_line (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] in_sample
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] out_sample
    output logic             m_tlast,   // last_in_line
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NC     = prs_pkg::NCELL;
    localparam int SW     = prs_pkg::SAMPLE_W;
    localparam int PW     = prs_pkg::PROD_W;
    localparam int PART_W = PW + 2;
    localparam int ACC_W  = PW + 4;
    localparam int PW_    = prs_pkg::POS_W;
    localparam int WW     = prs_pkg::WIDTH_W;

    typedef enum logic [0:0] {ST_IDLE, ST_PROC} state_t;

    state_t                 state_reg,  state_next;
    logic [PW_-1:0]         pos_reg,    pos_next;
    logic [WW-1:0]          vp_reg,     vp_next;
    logic [PW_-1:0]         j_reg,      j_next;
    logic [1:0]             ph_reg,     ph_next;
    logic [WW-1:0]          c_reg,      c_next;
    logic [prs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                   last_reg,   last_next;
    logic [WW-1:0]          width_reg;
    logic                   clip_reg;
    logic [PW_-1:0]         nout_reg;
    logic                   a_v_reg,    a_v_next;
    logic                   a_last_reg, a_last_next;
    logic                   b_v_reg;
    logic                   b_last_reg;
    logic signed [PART_W-1:0] part_reg [4];
    logic                   m_v_reg;
    logic                   m_last_reg;
    logic [15:0]            m_data_reg;

    prs_pkg::cell_ctl_t     cell_ctl;
    logic signed [SW-1:0]   shift_src;
    logic signed [SW-1:0]   prev_s [NC];
    logic signed [SW-1:0]   cell_q [NC];
    logic signed [PW-1:0]   cell_p [NC];

    logic                   accept;
    logic                   busy;
    logic                   can_emit;
    logic [WW-1:0]          w_eff;
    logic [13:0]            w3;
    logic [27:0]            nout_prod;
    logic                   cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    always_comb begin
        unique case (paddr[2])
            prs_pkg::REG_LINE_WIDTH: prdata = {{(32-WW){1'b0}}, width_reg};
            prs_pkg::REG_CLIP:       prdata = {31'b0, clip_reg};
            default:                 prdata = 32'b0;
        endcase
    end

    // Effective width and output count: nout = (3w * 13108) >> 16 = floor(3w/5)
    always_comb begin
        if (width_reg < prs_pkg::WIDTH_MIN) begin
            w_eff = prs_pkg::WIDTH_MIN;
        end else if (width_reg > prs_pkg::WIDTH_MAX) begin
            w_eff = prs_pkg::WIDTH_MAX;
        end else begin
            w_eff = width_reg;
        end
        w3        = {1'b0, w_eff} + {w_eff, 1'b0};
        nout_prod = 28'(w3) * 28'd13108;
    end

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign busy     = a_v_reg | b_v_reg | m_v_reg;
    assign can_emit = (j_reg < nout_reg) && (cnt_reg < prs_pkg::CNT_W'(prs_pkg::MAX_OUT));
    assign shift_src = (state_reg == ST_IDLE) ? $signed(s_tdata) : cell_q[0];

    // Sequencer: place each output, replicate the right edge at line end
    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        vp_next     = vp_reg;
        j_next      = j_reg;
        ph_next     = ph_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        a_v_next    = 1'b0;
        a_last_next = a_last_reg;
        cell_ctl    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cell_ctl.shift = 1'b1;
                    cell_ctl.fill  = (pos_reg == '0);
                    vp_next    = {1'b0, pos_reg};
                    last_next  = (({1'b0, pos_reg} + 13'd1) >= w_eff);
                    cnt_next   = '0;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (!busy) begin
                    if (can_emit && ((c_reg + WW'(prs_pkg::HALF_TAPS)) <= vp_reg)) begin
                        cell_ctl.mac = 1'b1;
                        a_v_next     = 1'b1;
                        a_last_next  = ((j_reg + 12'd1) == nout_reg);
                        j_next       = j_reg + 12'd1;
                        cnt_next     = cnt_reg + 4'd1;
                        case (ph_reg)
                            2'd0:    begin ph_next = 2'd1; c_next = c_reg + 13'd2; end
                            2'd1:    begin ph_next = 2'd2; c_next = c_reg + 13'd1; end
                            default: begin ph_next = 2'd0; c_next = c_reg + 13'd2; end
                        endcase
                    end else if (can_emit && last_reg) begin
                        cell_ctl.shift = 1'b1;
                        vp_next        = vp_reg + 13'd1;
                    end else begin
                        if (last_reg) begin
                            pos_next = '0;
                            j_next   = '0;
                            ph_next  = 2'd0;
                            c_next   = '0;
                        end else begin
                            pos_next = pos_reg + 12'd1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Window cells
    for (genvar k = 0; k < NC; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign prev_s[k] = shift_src;
        end else begin : g_body
            assign prev_s[k] = cell_q[k-1];
        end
        prs_cell u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl),
            .prev_sample (prev_s[k]),
            .fill_sample ($signed(s_tdata)),
            .coef        (prs_pkg::TAPS[ph_reg][NC-1-k]),
            .sample      (cell_q[k]),
            .prod        (cell_p[k])
        );
    end

    // Partial sums of the cell products
    logic signed [PART_W-1:0] part_c [4];
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            part_c[g] = '0;
            for (int m = 0; m < 4; m++) begin
                if (g * 4 + m < NC) begin
                    part_c[g] = part_c[g] + PART_W'(cell_p[g * 4 + m]);
                end
            end
        end
    end

    // Final sum, round half up to Q4, saturate or clip
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-17:0] q;
    logic [15:0]              res;
    always_comb begin
        acc = ACC_W'(part_reg[0]) + ACC_W'(part_reg[1])
            + ACC_W'(part_reg[2]) + ACC_W'(part_reg[3]);
        q   = (ACC_W-16)'((acc + ACC_W'(32768)) >>> 16);
        if (clip_reg) begin
            if (q < 0) begin
                res = 16'd0;
            end else if (q > 4080) begin
                res = 16'd4080;
            end else begin
                res = {q[15:4], 4'b0};
            end
        end else begin
            if (q > 32767) begin
                res = 16'h7FFF;
            end else if (q < -32768) begin
                res = 16'h8000;
            end else begin
                res = q[15:0];
            end
        end
    end

    // Control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            vp_reg     <= '0;
            j_reg      <= '0;
            ph_reg     <= 2'd0;
            c_reg      <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
            width_reg  <= prs_pkg::WIDTH_RESET;
            clip_reg   <= 1'b0;
            nout_reg   <= 12'd384;
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            m_v_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            vp_reg     <= vp_next;
            j_reg      <= j_next;
            ph_reg     <= ph_next;
            c_reg      <= c_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            nout_reg   <= nout_prod[27:16];
            if (cfg_wr) begin
                unique case (paddr[2])
                    prs_pkg::REG_LINE_WIDTH: width_reg <= pwdata[WW-1:0];
                    prs_pkg::REG_CLIP:       clip_reg  <= pwdata[0];
                    default: ;
                endcase
            end
            a_v_reg <= a_v_next;
            b_v_reg <= a_v_reg;
            if (b_v_reg) begin
                m_v_reg <= 1'b1;
            end else if (m_tready) begin
                m_v_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        a_last_reg <= a_last_next;
        if (a_v_reg) begin
            part_reg   <= part_c;
            b_last_reg <= a_last_reg;
        end
        if (b_v_reg) begin
            m_data_reg <= res;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    `ASSERT_ALWAYS(a_one_in_flight, aclk, aresetn, $onehot0({a_v_reg, b_v_reg, m_v_reg}), "more than one result in flight")
    `ASSERT_IMPL(a_idle_empty, aclk, aresetn, s_tready, !busy, "input ready while a result is pending")
    `ASSERT_IMPL(a_clip_fmt, aclk, aresetn, m_v_reg && clip_reg, (m_data_reg[3:0] == 4'd0) && !m_data_reg[15], "clipped word out of byte range")

endmodule
`default_nettype wire
